[design/pidsc_pkg.sv]
// Shared types and constants for the multichannel PID speed controller.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pidsc_pkg;

    localparam int NUM_CHANNELS   = 4;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int CH_IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // error is 17 bit, derivative 18 bit, integral 32 bit, gains 16 bit unsigned
    localparam int ERR_W   = 17;
    localparam int DER_W   = 18;
    localparam int INT_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + INT_W;
    localparam int PROD_D_W = GAIN_W + 1 + DER_W;
    localparam int SUM_W    = PROD_I_W + 2;
    localparam int QUOT_W   = SUM_W - GAIN_FRAC_BITS;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P      = 4'd0,
        CFG_GAIN_I      = 4'd1,
        CFG_GAIN_D      = 4'd2,
        CFG_DRIVE_LIMIT = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
    } t_in;

    typedef struct packed {
        logic [1:0]  channel_out;
        logic [15:0] drive_value;
        logic        clamped;
    } t_out;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [15:0]       drive_limit;
    } t_cfg;

    // classified request handed from the front to the back
    typedef struct packed {
        logic [1:0]              channel;
        logic                    active;
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] integ;
        logic signed [DER_W-1:0] deriv;
    } t_job;

endpackage

`default_nettype wire

[design/pidsc_front.sv]
// Front end: error, saturating integral and derivative per channel.
// Holds the per-channel loop state. Depends on pidsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidsc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire pidsc_pkg::t_in  i_req,
    output pidsc_pkg::t_job      o_job
);
    import pidsc_pkg::*;

    logic signed [INT_W-1:0] r_err_sum  [NUM_CHANNELS];
    logic signed [ERR_W-1:0] r_last_err [NUM_CHANNELS];

    logic [CH_IDX_W-1:0]     w_idx;
    logic                    w_active;
    logic signed [ERR_W-1:0] w_err;
    logic signed [INT_W:0]   w_wide;
    logic signed [INT_W-1:0] n_err_sum;
    logic signed [DER_W-1:0] w_deriv;

    assign w_idx    = CH_IDX_W'(i_req.channel);
    assign w_active = 32'(i_req.channel) < NUM_CHANNELS;
    assign w_err    = {i_req.target_speed[15], i_req.target_speed}
                    - {i_req.measured_speed[15], i_req.measured_speed};
    assign w_wide   = {r_err_sum[w_idx][INT_W-1], r_err_sum[w_idx]}
                    + {{(INT_W+1-ERR_W){w_err[ERR_W-1]}}, w_err};
    assign w_deriv  = {w_err[ERR_W-1], w_err}
                    - {r_last_err[w_idx][ERR_W-1], r_last_err[w_idx]};

    // saturate on overflow of the 32-bit integral
    always_comb begin
        if (w_wide[INT_W] != w_wide[INT_W-1]) begin
            n_err_sum = w_wide[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                      : {1'b0, {(INT_W-1){1'b1}}};
        end else begin
            n_err_sum = w_wide[INT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_err_sum[k]  <= '0;
                r_last_err[k] <= '0;
            end
        end else if (i_accept && w_active) begin
            r_err_sum[w_idx]  <= n_err_sum;
            r_last_err[w_idx] <= w_err;
        end
    end

    always_comb begin
        o_job.channel = i_req.channel;
        o_job.active  = w_active;
        o_job.err     = w_err;
        o_job.integ   = n_err_sum;
        o_job.deriv   = w_deriv;
    end

`ifndef NO_ASSERTIONS
    a_last_err_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_active) |=> r_last_err[$past(w_idx)] == $past(w_err))
        else $error("last error not stored for stepped channel");
`endif

endmodule

`default_nettype wire

[design/pidsc_queue.sv]
// Short request queue between the front end and the arithmetic back end.
// Depends on pidsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidsc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire pidsc_pkg::t_job i_push_data,
    output logic                 o_full,
    output logic                 o_pop_valid,
    input  wire logic            i_pop,
    output pidsc_pkg::t_job      o_pop_data
);
    import pidsc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full      = r_count == Q_CNT_W'(Q_DEPTH);
    assign o_pop_valid = r_count != '0;
    assign o_pop_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_pop_valid)
        else $error("request popped from empty queue");
`endif

endmodule

`default_nettype wire

[design/pidsc_back.sv]
// Back end: three gain products, their sum, truncating shift and clamp.
// Three register stages with stall propagation. Depends on pidsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidsc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pidsc_pkg::t_cfg i_cfg,
    input  wire logic            i_job_valid,
    input  wire pidsc_pkg::t_job i_job,
    output logic                 o_job_pop,
    output logic                 o_out_valid,
    output pidsc_pkg::t_out      o_out_data,
    input  wire logic            i_out_stall
);
    import pidsc_pkg::*;

    // stage 1: products
    logic                       r_s1_v;
    logic [1:0]                 r_s1_ch;
    logic                       r_s1_active;
    logic signed [PROD_P_W-1:0] r_prod_p;
    logic signed [PROD_I_W-1:0] r_prod_i;
    logic signed [PROD_D_W-1:0] r_prod_d;
    // stage 2: sum
    logic                       r_s2_v;
    logic [1:0]                 r_s2_ch;
    logic                       r_s2_active;
    logic signed [SUM_W-1:0]    r_sum;
    // output register
    logic                       r_out_v;
    logic                       r_out_active;
    t_out                       r_out;

    logic                       w_out_free;
    logic                       w_s2_free;
    logic                       w_s1_free;
    logic signed [PROD_P_W-1:0] w_prod_p;
    logic signed [PROD_I_W-1:0] w_prod_i;
    logic signed [PROD_D_W-1:0] w_prod_d;
    logic [QUOT_W-1:0]          w_quot;
    logic                       w_small_neg;
    t_out                       n_out;

    assign w_out_free = !r_out_v || !i_out_stall;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign o_job_pop  = i_job_valid && w_s1_free;

    assign w_prod_p = $signed({1'b0, i_cfg.gain_p}) * i_job.err;
    assign w_prod_i = $signed({1'b0, i_cfg.gain_i}) * i_job.integ;
    assign w_prod_d = $signed({1'b0, i_cfg.gain_d}) * i_job.deriv;

    // truncation toward zero: a negative sum above -2^frac truncates to zero
    assign w_quot      = r_sum[SUM_W-1:GAIN_FRAC_BITS];
    assign w_small_neg = (&w_quot) && (|r_sum[GAIN_FRAC_BITS-1:0]);

    always_comb begin
        n_out.channel_out = r_s2_ch;
        n_out.drive_value = '0;
        n_out.clamped     = 1'b0;
        if (r_s2_active) begin
            if (r_sum[SUM_W-1]) begin
                n_out.clamped = !w_small_neg;
            end else if (w_quot > QUOT_W'(i_cfg.drive_limit)) begin
                n_out.drive_value = i_cfg.drive_limit;
                n_out.clamped     = 1'b1;
            end else begin
                n_out.drive_value = w_quot[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_ch     <= i_job.channel;
            r_s1_active <= i_job.active;
            r_prod_p    <= w_prod_p;
            r_prod_i    <= w_prod_i;
            r_prod_d    <= w_prod_d;
        end
        if (w_s2_free) begin
            r_s2_ch     <= r_s1_ch;
            r_s2_active <= r_s1_active;
            r_sum       <= SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
        end
        if (w_out_free) begin
            r_out        <= n_out;
            r_out_active <= r_s2_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= i_job_valid;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (w_out_free) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out.drive_value <= i_cfg.drive_limit)
        else $error("drive value above limit");
    a_idle_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_active) |-> (r_out.drive_value == '0 && !r_out.clamped))
        else $error("absent channel produced a drive");
`endif

endmodule

`default_nettype wire

[design/multichannel_pid_speed_control.sv]
// Four-channel positional PID speed controller: top level with config registers.
// Depends on pidsc_pkg, pidsc_front, pidsc_queue and pidsc_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock while o_in_stall is low and returns one drive
// result per request, in order. The front end updates the channel's integral
// and last error in the cycle the request is taken, and a four-entry queue
// feeds a three-stage back end (products, sum, clamp and output register); the
// sustained rate is one request per cycle while the output is not stalled. A
// stalled output fills the back end and then the queue before o_in_stall rises.
// Gains and the drive limit are shared by all channels and should only be
// written while no request is in flight; the config port is always ready.
module multichannel_pid_speed_control (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire pidsc_pkg::t_in             i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output pidsc_pkg::t_out                 o_out_data,
    input  wire logic                       i_out_stall,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [pidsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                i_cfg_data
);
    import pidsc_pkg::*;

    t_cfg r_cfg;
    t_job w_front_job;
    t_job w_queue_job;
    logic w_accept;
    logic w_full;
    logic w_job_valid;
    logic w_job_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p      <= 16'd256;
            r_cfg.gain_i      <= 16'd0;
            r_cfg.gain_d      <= 16'd0;
            r_cfg.drive_limit <= 16'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GAIN_P:      r_cfg.gain_p      <= i_cfg_data;
                CFG_GAIN_I:      r_cfg.gain_i      <= i_cfg_data;
                CFG_GAIN_D:      r_cfg.gain_d      <= i_cfg_data;
                CFG_DRIVE_LIMIT: r_cfg.drive_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pidsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_in_data),
        .o_job    (w_front_job)
    );

    pidsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_push_data (w_front_job),
        .o_full      (w_full),
        .o_pop_valid (w_job_valid),
        .i_pop       (w_job_pop),
        .o_pop_data  (w_queue_job)
    );

    pidsc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_queue_job),
        .o_job_pop   (w_job_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for multichannel_pid_speed_control: feeds speed requests and
// register writes, predicts each drive result in software and checks them in order.
// Depends on pidsc_pkg and the multichannel_pid_speed_control top level.
`timescale 1ns / 1ps

module tb;
    import pidsc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BLOCK = 170;
    localparam int WINDUP_STEPS = 16;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    t_in                  in_data = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out_data;
    logic                 o_cfg_ready;

    // shadow of the controller: shared gains and per-channel loop state
    logic [15:0]        cfg_kp, cfg_ki, cfg_kd, cfg_limit;
    logic signed [31:0] err_sum [NUM_CHANNELS];
    logic signed [16:0] prev_err [NUM_CHANNELS];

    t_in  speed_reqs[$];
    t_out due_drives[$];
    t_out drive_want;
    int   n_queued = 0;
    int   n_taken = 0;
    int   n_bad = 0;
    int   quiet_cycles = 0;
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;

    multichannel_pid_speed_control dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Advances one channel's loop and returns the drive it should produce.
    function automatic t_out step_pid(t_in req);
        t_out   res;
        longint err, integ, slope, total, quot;
        int unsigned ch;
        ch = req.channel;
        res = '0;
        res.channel_out = req.channel;
        if (ch < NUM_CHANNELS) begin
            err = longint'($signed(req.target_speed)) - longint'($signed(req.measured_speed));
            integ = longint'(err_sum[ch]) + err;
            if (integ > 64'sh7FFF_FFFF)
                integ = 64'sh7FFF_FFFF;
            else if (integ < -64'sh8000_0000)
                integ = -64'sh8000_0000;
            err_sum[ch] = integ[31:0];
            slope = err - longint'(prev_err[ch]);
            prev_err[ch] = err[16:0];
            total = longint'(cfg_kp) * err + longint'(cfg_ki) * integ
                  + longint'(cfg_kd) * slope;
            // signed division truncates toward zero, as the shift of the magnitude does
            quot = total / (64'sd1 << GAIN_FRAC_BITS);
            if (quot < 0) begin
                res.clamped = 1'b1;
            end else if (quot > longint'(cfg_limit)) begin
                res.drive_value = cfg_limit;
                res.clamped = 1'b1;
            end else begin
                res.drive_value = quot[15:0];
            end
        end
        return res;
    endfunction

    function automatic logic [15:0] corner_speed(int unsigned sel);
        case (sel)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic t_in random_speed_req();
        t_in r;
        int unsigned mode;
        mode = $urandom_range(7);
        r.channel = 2'($urandom_range(3));
        r.target_speed = 16'($urandom);
        if (mode < 2) begin
            r.measured_speed = 16'($urandom);
        end else if (mode < 6) begin
            // small error keeps the drive inside the clamp most of the time
            r.measured_speed = r.target_speed + 16'($urandom_range(600)) - 16'd300;
        end else if (mode == 6) begin
            r.target_speed = corner_speed($urandom_range(3));
            r.measured_speed = corner_speed($urandom_range(3));
        end else begin
            r.measured_speed = r.target_speed;
        end
        return r;
    endfunction

    task automatic queue_req(int ch, int tgt, int meas);
        t_in r;
        r.channel = ch[1:0];
        r.target_speed = tgt[15:0];
        r.measured_speed = meas[15:0];
        speed_reqs.push_back(r);
        n_queued++;
    endtask

    task automatic note_mismatch(string what, longint want, longint got);
        if (n_bad < 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        n_bad++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GAIN_P:      cfg_kp = val;
            CFG_GAIN_I:      cfg_ki = val;
            CFG_GAIN_D:      cfg_kd = val;
            CFG_DRIVE_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                             logic [15:0] lim);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_DRIVE_LIMIT, lim);
    endtask

    // wait until every request is taken and every drive returned
    task automatic settle();
        while (n_taken != n_queued || due_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(int count);
        for (int k = 0; k < count; k++) begin
            speed_reqs.push_back(random_speed_req());
            n_queued++;
        end
        settle();
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                due_drives.push_back(step_pid(in_data));
                n_taken++;
            end
            if (!in_valid || !o_in_stall) begin
                if (speed_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_data  <= speed_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (due_drives.size() == 0) begin
                    if (n_bad < 10)
                        $display("%0t: drive result with no request outstanding", $realtime);
                    n_bad++;
                end else begin
                    drive_want = due_drives.pop_front();
                    if (o_out_data.channel_out !== drive_want.channel_out)
                        note_mismatch("channel_out", drive_want.channel_out,
                                      o_out_data.channel_out);
                    if (o_out_data.drive_value !== drive_want.drive_value)
                        note_mismatch("drive_value", drive_want.drive_value,
                                      o_out_data.drive_value);
                    if (o_out_data.clamped !== drive_want.clamped)
                        note_mismatch("clamped", drive_want.clamped, o_out_data.clamped);
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** multichannel_pid_speed_control: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cfg_kp = 16'd256;
        cfg_ki = 16'd0;
        cfg_kd = 16'd0;
        cfg_limit = 16'd255;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            err_sum[c] = '0;
            prev_err[c] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset gains: unity proportional, limit 255
        queue_req(0, 100, 0);
        queue_req(0, 0, 100);
        queue_req(1, 32767, -32768);
        queue_req(1, -32768, 32767);
        queue_req(2, 5, 5);
        queue_req(3, 255, 0);
        queue_req(3, 256, 0);
        settle();

        // half gain: fractions truncate toward zero, -0.5 is not clamped
        set_gains(16'd128, 16'd0, 16'd0, 16'd255);
        queue_req(0, 1, 0);
        queue_req(0, -1, 0);
        queue_req(0, -3, 0);
        settle();

        // integral and derivative only; writes to unmapped indexes must be ignored
        set_gains(16'd0, 16'd256, 16'd256, 16'd65535);
        write_reg(4'($urandom_range(15, 8)), 16'hFFFF);
        write_reg(4'($urandom_range(7, 4)), 16'h0000);
        queue_req(1, 10, 0);
        queue_req(1, 10, 0);
        queue_req(1, 0, 5);
        queue_req(1, -20, 0);
        settle();

        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(2, 32767, -32768);
        queue_req(2, -32768, 32767);
        queue_req(3, 1, 0);
        settle();

        send_gap_pct = 35;
        recv_stall_pct = 50;
        set_gains(16'd256, 16'd16, 16'd64, 16'd1000);
        run_random(RANDOM_BLOCK);
        set_gains(16'd1, 16'd1, 16'd1, 16'hFFFF);
        run_random(RANDOM_BLOCK);

        send_gap_pct = 50;
        recv_stall_pct = 35;
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_BLOCK);
        set_gains(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(RANDOM_BLOCK);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_gains(16'($urandom_range(1024)), 16'($urandom_range(64)),
                  16'($urandom_range(512)), 16'($urandom_range(65535)));
        run_random(RANDOM_BLOCK);
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(RANDOM_BLOCK);

        // integral wind-up: push channel 2 up and channel 3 down with full-scale
        // errors, then step back off both
        set_gains(16'd0, 16'd1, 16'd0, 16'hFFFF);
        for (int k = 0; k < WINDUP_STEPS; k++) begin
            queue_req(2, 32767, -32768);
            queue_req(3, -32768, 32767);
        end
        for (int k = 0; k < 3; k++) begin
            queue_req(2, -32768, 32767);
            queue_req(3, 32767, -32768);
        end
        settle();

        if (n_bad == 0 && due_drives.size() == 0)
            $display("** multichannel_pid_speed_control: PASSED **");
        else
            $display("** multichannel_pid_speed_control: FAILED **");
        $finish;
    end

endmodule
